// ===== sv/cps_pkg.sv =====
package cps_pkg;

   localparam int ADC_BITS  = 12;
   localparam int TIME_BITS = 32;
   localparam int TRY_BITS  = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [TRY_BITS-1:0] TRY_MAX = '1;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BOARD_IS_COMMON      = 3'd0,
      CSR_MAX_CLOSE_TRIES      = 3'd1,
      CSR_PRECHARGE_DONE_LEVEL = 3'd2,
      CSR_SENSE_DRIVE_DELAY    = 3'd3,
      CSR_PRECHARGE_DELAY      = 3'd4,
      CSR_CLOSE_CHECK_DELAY    = 3'd5,
      CSR_OPEN_VERIFY_DELAY    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_OPEN    = 3'd0,
      PH_PRE1    = 3'd1,
      PH_PRE2    = 3'd2,
      PH_CLOSING = 3'd3,
      PH_CLOSED  = 3'd4
   } phase_type;

   typedef struct packed {
      logic                 board_is_common;
      logic [TRY_BITS-1:0]  max_close_tries;
      logic [ADC_BITS-1:0]  precharge_done_level;
      logic [TIME_BITS-1:0] sense_drive_delay_us;
      logic [TIME_BITS-1:0] precharge_delay_us;
      logic [TIME_BITS-1:0] close_check_delay_us;
      logic [TIME_BITS-1:0] open_verify_delay_us;
   } cfg_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [REQ_DATA_BITS-TIME_BITS-ADC_BITS-3:0] pad;
      logic [ADC_BITS-1:0]                          precharge_adc;
      logic                                         aux_closed;
      logic                                         close_command;
      logic [TIME_BITS-1:0]                         now_us;
   } req_item_type;

   typedef struct packed {
      logic [RSP_DATA_BITS-11:0] pad;
      logic                      bps_error;
      logic                      switch_error;
      logic                      precharge_done;
      logic                      contactor_sensed;
      phase_type                 phase;
      logic                      contactor_on;
      logic                      sense_drive;
      logic                      precharge_on;
   } rsp_item_type;

endpackage

// ===== sv/contactor_precharge_sequencer_top.sv =====
// Contactor precharge sequencer. Each req item is one task tick (timestamp, close
// command, auxiliary sense, precharge ADC sample) and yields exactly one rsp item
// with the switch drives, the phase and the error flags after that tick. The
// block takes one item per clock while rsp is not stalled. An accepted item waits
// in the input register until the result register is free, and the combinational
// state update then writes its rsp item into the result register. While rsp is
// stalled the input register still takes one more item, then req_tready drops.
// The user must write registers on the csr port only while no item is in flight;
// the block itself does not enforce this.
module contactor_precharge_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_us[31:0], close_command[32], aux_closed[33], precharge_adc[45:34], zero
   input  logic [cps_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // precharge_on[0], sense_drive[1], contactor_on[2], phase[5:3],
   // contactor_sensed[6], precharge_done[7], switch_error[8], bps_error[9], zero
   output logic [cps_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [cps_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cps_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cps_pkg::*;

   cfg_type      cfg;
   req_item_type item_ff;
   logic         item_valid_ff, item_valid_in;
   rsp_item_type result;
   rsp_item_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         req_take;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);

   cps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cps_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item_type'(req_tdata);
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);

endmodule

// ===== sv/cps_csr.sv =====
module cps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cps_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cps_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output cps_pkg::cfg_type                    cfg
);
   import cps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOARD_IS_COMMON:      cfg_in.board_is_common = csr_wdata[0];
            CSR_MAX_CLOSE_TRIES:      cfg_in.max_close_tries = csr_wdata[TRY_BITS-1:0];
            CSR_PRECHARGE_DONE_LEVEL: cfg_in.precharge_done_level = csr_wdata[ADC_BITS-1:0];
            CSR_SENSE_DRIVE_DELAY:    cfg_in.sense_drive_delay_us = csr_wdata[TIME_BITS-1:0];
            CSR_PRECHARGE_DELAY:      cfg_in.precharge_delay_us = csr_wdata[TIME_BITS-1:0];
            CSR_CLOSE_CHECK_DELAY:    cfg_in.close_check_delay_us = csr_wdata[TIME_BITS-1:0];
            CSR_OPEN_VERIFY_DELAY:    cfg_in.open_verify_delay_us = csr_wdata[TIME_BITS-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_is_common      <= 1'b0;
         cfg_ff.max_close_tries      <= TRY_BITS'(3);
         cfg_ff.precharge_done_level <= ADC_BITS'(2048);
         cfg_ff.sense_drive_delay_us <= TIME_BITS'(10000);
         cfg_ff.precharge_delay_us   <= TIME_BITS'(1000000);
         cfg_ff.close_check_delay_us <= TIME_BITS'(250000);
         cfg_ff.open_verify_delay_us <= TIME_BITS'(1000000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/cps_fsm.sv =====
module cps_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  cps_pkg::req_item_type item,
   input  cps_pkg::cfg_type      cfg,
   output cps_pkg::rsp_item_type result
);
   import cps_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TRY_BITS-1:0]  tries_ff, tries_in;
   logic                 sw_err_ff, sw_err_in;
   logic                 bps_err_ff, bps_err_in;
   logic                 pre_ff, pre_in;
   logic                 sense_ff, sense_in;
   logic                 coil_ff, coil_in;

   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS-1:0] delay_sel;
   logic                 expired;
   logic [TRY_BITS-1:0]  tries_inc;
   logic                 tries_spent;
   logic                 close;
   logic                 common;

   assign close  = item.close_command;
   assign common = cfg.board_is_common;

   // wrapping timestamp difference against the delay of the current phase
   always_comb begin
      unique case (phase_ff)
         PH_OPEN:    delay_sel = cfg.open_verify_delay_us;
         PH_PRE1:    delay_sel = cfg.sense_drive_delay_us;
         PH_PRE2:    delay_sel = cfg.precharge_delay_us;
         PH_CLOSING: delay_sel = cfg.close_check_delay_us;
         default:    delay_sel = '0;
      endcase
   end

   assign elapsed     = item.now_us - start_ff;
   assign expired     = elapsed >= delay_sel;
   assign tries_inc   = (tries_ff == TRY_MAX) ? tries_ff : tries_ff + TRY_BITS'(1);
   assign tries_spent = tries_inc >= cfg.max_close_tries;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_OPEN: begin
            if (close) begin
               phase_in = common ? PH_CLOSING : PH_PRE1;
            end
         end
         PH_PRE1: begin
            if (!close) begin
               phase_in = PH_OPEN;
            end else if (expired) begin
               phase_in = PH_PRE2;
            end
         end
         PH_PRE2: begin
            if (!close) begin
               phase_in = PH_OPEN;
            end else if (expired) begin
               phase_in = PH_CLOSING;
            end
         end
         PH_CLOSING: begin
            priority if (!close) begin
               phase_in = PH_OPEN;
            end else if (expired && item.aux_closed) begin
               phase_in = PH_CLOSED;
            end else if (expired && tries_spent) begin
               phase_in = PH_OPEN;
            end
         end
         PH_CLOSED: begin
            if (!close) begin
               phase_in = PH_OPEN;
            end
         end
         default: phase_in = PH_OPEN;
      endcase
   end

   // drives, timer, try counter and error flags
   always_comb begin
      start_in   = start_ff;
      tries_in   = tries_ff;
      sw_err_in  = sw_err_ff;
      bps_err_in = bps_err_ff;
      pre_in     = pre_ff;
      sense_in   = sense_ff;
      coil_in    = coil_ff;
      unique case (phase_ff)
         PH_OPEN: begin
            if (close) begin
               start_in = item.now_us;
               if (!common) begin
                  sense_in = 1'b1;
               end else begin
                  coil_in = 1'b1;
               end
            end else begin
               pre_in   = 1'b0;
               sense_in = 1'b0;
               coil_in  = 1'b0;
               if (expired) begin
                  bps_err_in = item.aux_closed;
               end
            end
         end
         PH_PRE1, PH_PRE2, PH_CLOSED: begin
            if (!close) begin
               pre_in   = 1'b0;
               sense_in = 1'b0;
               coil_in  = 1'b0;
               start_in = item.now_us;
            end else if (expired && phase_ff != PH_CLOSED) begin
               start_in = item.now_us;
               if (phase_ff == PH_PRE1) begin
                  if (!common) begin
                     pre_in = 1'b1;
                  end
               end else begin
                  coil_in = 1'b1;
               end
            end
         end
         PH_CLOSING: begin
            if (!close) begin
               pre_in   = 1'b0;
               sense_in = 1'b0;
               coil_in  = 1'b0;
               start_in = item.now_us;
            end else if (expired) begin
               if (item.aux_closed) begin
                  pre_in   = 1'b0;
                  sense_in = 1'b0;
               end else begin
                  start_in = item.now_us;
                  tries_in = tries_inc;
                  if (tries_spent) begin
                     pre_in    = 1'b0;
                     sense_in  = 1'b0;
                     coil_in   = 1'b0;
                     sw_err_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            pre_in    = 1'b0;
            sense_in  = 1'b0;
            coil_in   = 1'b0;
            start_in  = item.now_us;
            sw_err_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPEN;
         start_ff   <= '0;
         tries_ff   <= '0;
         sw_err_ff  <= 1'b0;
         bps_err_ff <= 1'b0;
         pre_ff     <= 1'b0;
         sense_ff   <= 1'b0;
         coil_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         tries_ff   <= tries_in;
         sw_err_ff  <= sw_err_in;
         bps_err_ff <= bps_err_in;
         pre_ff     <= pre_in;
         sense_ff   <= sense_in;
         coil_ff    <= coil_in;
      end
   end

   // result shows the state after this item's update
   always_comb begin
      result                  = '0;
      result.precharge_on     = pre_in;
      result.sense_drive      = sense_in;
      result.contactor_on     = coil_in;
      result.phase            = phase_in;
      result.contactor_sensed = item.aux_closed;
      result.precharge_done   = !common && (item.precharge_adc >= cfg.precharge_done_level);
      result.switch_error     = sw_err_in;
      result.bps_error        = bps_err_in;
   end

endmodule

// ===== tb/sequencer_checker.sv =====
`timescale 1ns / 100ps

module sequencer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [cps_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [cps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [cps_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cps_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                fail_count,
   output int                                ticks_in_flight
);
   import cps_pkg::*;

   // shadow of the csr registers and the sequencer state
   cfg_type              settings;
   phase_type            phase_now;
   logic [TIME_BITS-1:0] phase_start;
   logic [TRY_BITS-1:0]  close_tries;
   logic                 switch_flag;
   logic                 bps_flag;
   logic                 pre_pin;
   logic                 sense_pin;
   logic                 coil_pin;

   rsp_item_type expected_outputs[$];
   int           fail_total = 0;
   int           results_seen = 0;

   assign fail_count = fail_total;

   task automatic report(string what);
      fail_total++;
      if (fail_total <= 40)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(string field, int got, int want);
      if (got != want)
         report($sformatf("result %0d %s = %0d, want %0d", results_seen, field, got, want));
   endtask

   function automatic void open_all(logic [TIME_BITS-1:0] stamp);
      {pre_pin, sense_pin, coil_pin} = '0;
      phase_now = PH_OPEN;
      phase_start = stamp;
   endfunction

   function automatic rsp_item_type advance_tick(req_item_type t);
      rsp_item_type         r;
      logic [TIME_BITS-1:0] since;
      logic                 common;
      common = settings.board_is_common;
      // wrapping elapsed time since the phase began
      since = t.now_us - phase_start;
      case (phase_now)
         PH_OPEN: begin
            if (t.close_command) begin
               phase_start = t.now_us;
               if (!common) begin
                  sense_pin = 1'b1;
                  phase_now = PH_PRE1;
               end else begin
                  coil_pin = 1'b1;
                  phase_now = PH_CLOSING;
               end
            end else begin
               {pre_pin, sense_pin, coil_pin} = '0;
               if (since >= settings.open_verify_delay_us)
                  bps_flag = t.aux_closed;
            end
         end
         PH_PRE1: begin
            if (!t.close_command) begin
               open_all(t.now_us);
            end else if (since >= settings.sense_drive_delay_us) begin
               if (!common)
                  pre_pin = 1'b1;
               phase_start = t.now_us;
               phase_now = PH_PRE2;
            end
         end
         PH_PRE2: begin
            if (!t.close_command) begin
               open_all(t.now_us);
            end else if (since >= settings.precharge_delay_us) begin
               coil_pin = 1'b1;
               phase_start = t.now_us;
               phase_now = PH_CLOSING;
            end
         end
         PH_CLOSING: begin
            if (!t.close_command) begin
               open_all(t.now_us);
            end else if (since >= settings.close_check_delay_us) begin
               if (t.aux_closed) begin
                  pre_pin = 1'b0;
                  sense_pin = 1'b0;
                  phase_now = PH_CLOSED;
               end else begin
                  // tries are never cleared, only saturated
                  phase_start = t.now_us;
                  if (close_tries != TRY_MAX)
                     close_tries++;
                  if (close_tries >= settings.max_close_tries) begin
                     {pre_pin, sense_pin, coil_pin} = '0;
                     phase_now = PH_OPEN;
                     switch_flag = 1'b1;
                  end
               end
            end
         end
         PH_CLOSED: begin
            if (!t.close_command)
               open_all(t.now_us);
         end
         default: begin
            open_all(t.now_us);
            switch_flag = 1'b1;
         end
      endcase
      r = '0;
      r.precharge_on = pre_pin;
      r.sense_drive = sense_pin;
      r.contactor_on = coil_pin;
      r.phase = phase_now;
      r.contactor_sensed = t.aux_closed;
      r.precharge_done = !common && (t.precharge_adc >= settings.precharge_done_level);
      r.switch_error = switch_flag;
      r.bps_error = bps_flag;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         settings.board_is_common = 1'b0;
         settings.max_close_tries = 4'd3;
         settings.precharge_done_level = 12'd2048;
         settings.sense_drive_delay_us = 32'd10000;
         settings.precharge_delay_us = 32'd1000000;
         settings.close_check_delay_us = 32'd250000;
         settings.open_verify_delay_us = 32'd1000000;
         phase_now = PH_OPEN;
         phase_start = '0;
         close_tries = '0;
         switch_flag = 1'b0;
         bps_flag = 1'b0;
         {pre_pin, sense_pin, coil_pin} = '0;
         expected_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BOARD_IS_COMMON:      settings.board_is_common = csr_wdata[0];
               CSR_MAX_CLOSE_TRIES:      settings.max_close_tries = csr_wdata[TRY_BITS-1:0];
               CSR_PRECHARGE_DONE_LEVEL: settings.precharge_done_level = csr_wdata[ADC_BITS-1:0];
               CSR_SENSE_DRIVE_DELAY:    settings.sense_drive_delay_us = csr_wdata;
               CSR_PRECHARGE_DELAY:      settings.precharge_delay_us = csr_wdata;
               CSR_CLOSE_CHECK_DELAY:    settings.close_check_delay_us = csr_wdata;
               CSR_OPEN_VERIFY_DELAY:    settings.open_verify_delay_us = csr_wdata;
               default: ;
            endcase
         end
         // pop before push: a result never belongs to the item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (expected_outputs.size() == 0) begin
               report($sformatf("result %0d arrived with no tick pending", results_seen));
            end else begin
               want = expected_outputs.pop_front();
               check_field("precharge_on", got.precharge_on, want.precharge_on);
               check_field("sense_drive", got.sense_drive, want.sense_drive);
               check_field("contactor_on", got.contactor_on, want.contactor_on);
               check_field("phase", int'(got.phase), int'(want.phase));
               check_field("contactor_sensed", got.contactor_sensed, want.contactor_sensed);
               check_field("precharge_done", got.precharge_done, want.precharge_done);
               check_field("switch_error", got.switch_error, want.switch_error);
               check_field("bps_error", got.bps_error, want.bps_error);
            end
         end
         if (req_tvalid && req_tready)
            expected_outputs.push_back(advance_tick(req_tdata));
      end
      ticks_in_flight <= expected_outputs.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import cps_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int STEP_MAX = 8;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // now_us[31:0], close_command[32], aux_closed[33], precharge_adc[45:34], zero
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // precharge_on[0], sense_drive[1], contactor_on[2], phase[5:3],
   // contactor_sensed[6], precharge_done[7], switch_error[8], bps_error[9], zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_BOARD_IS_COMMON;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int                       fail_count;
   int                       ticks_in_flight;

   bit                   long_hold = 1'b0;
   int                   burst_left = 0;
   int                   close_left = 0;
   logic                 close_level = 1'b0;
   logic [TIME_BITS-1:0] now_time = '0;

   contactor_precharge_sequencer_top uut (.*);

   sequencer_checker u_checker (.*);

   initial forever #6 clock = ~clock;

   // receiver: changing stall patterns, plus one long hold-off on request
   initial begin : receiver
      ready_mode_type mode;
      int             mode_left;
      mode = READY_ALWAYS;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         if (mode_left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(4, 60);
         end
         mode_left--;
         case (mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
            default:      rsp_tready <= mode_left[1];
         endcase
      end
   end

   // any cycle with an accepted item on either side resets the count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic offer(req_item_type t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tdata <= t;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic tick(logic [TIME_BITS-1:0] stamp, logic close, logic aux,
                       logic [ADC_BITS-1:0] adc);
      req_item_type t;
      t = '0;
      t.now_us = stamp;
      t.close_command = close;
      t.aux_closed = aux;
      t.precharge_adc = adc;
      offer(t);
   endtask

   // close requests come in held runs, with an occasional glitch
   task automatic random_tick(bit wide);
      req_item_type t;
      int           roll;
      t = '0;
      if (close_left == 0) begin
         close_level = ~close_level;
         close_left = close_level ? $urandom_range(1, 40) : $urandom_range(1, 12);
      end
      close_left--;
      roll = $urandom_range(0, 99);
      if (wide || roll >= 96)
         now_time = $urandom();
      else if (roll >= 80)
         now_time += $urandom_range(0, 2);
      else
         now_time += $urandom_range(0, STEP_MAX);
      t.now_us = now_time;
      t.close_command = ($urandom_range(0, 19) == 0) ? ~close_level : close_level;
      t.aux_closed = close_level ? ($urandom_range(0, 99) < 55) : ($urandom_range(0, 99) < 30);
      t.precharge_adc = ($urandom_range(0, 9) == 0) ? {ADC_BITS{close_level}} :
                        ADC_BITS'($urandom_range(0, 4095));
      offer(t);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (ticks_in_flight != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // narrow registers get random junk above their width
   task automatic program_settings(cfg_type c);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = $urandom();
      put_reg(CSR_BOARD_IS_COMMON, {junk[31:1], c.board_is_common});
      put_reg(CSR_MAX_CLOSE_TRIES, {junk[31:TRY_BITS], c.max_close_tries});
      put_reg(CSR_PRECHARGE_DONE_LEVEL, {junk[31:ADC_BITS], c.precharge_done_level});
      put_reg(CSR_SENSE_DRIVE_DELAY, c.sense_drive_delay_us);
      put_reg(CSR_PRECHARGE_DELAY, c.precharge_delay_us);
      put_reg(CSR_CLOSE_CHECK_DELAY, c.close_check_delay_us);
      put_reg(CSR_OPEN_VERIFY_DELAY, c.open_verify_delay_us);
      put_reg(CSR_SPARE_INDEX, $urandom());
      csr_we <= 1'b0;
   endtask

   function automatic logic [TIME_BITS-1:0] pick_delay();
      return ($urandom_range(0, 7) == 0) ? TIME_BITS'($urandom()) :
                                          TIME_BITS'($urandom_range(0, 8));
   endfunction

   initial begin : stimulus
      cfg_type cfg;
      int      count;
      bit      wide;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // power-up settings: bps check, full close, retries, abort, exhaustion, wrap
      tick(32'd0, 1'b0, 1'b1, 12'd0);
      tick(32'd999_999, 1'b0, 1'b1, 12'd4095);
      tick(32'd1_000_000, 1'b0, 1'b1, 12'd2047);
      tick(32'd1_000_001, 1'b0, 1'b0, 12'd2048);
      tick(32'd1_500_000, 1'b1, 1'b0, 12'd100);
      tick(32'd1_509_999, 1'b1, 1'b0, 12'd3000);
      tick(32'd1_510_000, 1'b1, 1'b1, 12'd3000);
      tick(32'd1_600_000, 1'b0, 1'b1, 12'd500);
      tick(32'd1_600_001, 1'b1, 1'b0, 12'd2500);
      tick(32'd1_610_001, 1'b1, 1'b0, 12'd2600);
      tick(32'd2_610_001, 1'b1, 1'b0, 12'd4000);
      tick(32'd2_860_001, 1'b1, 1'b0, 12'd4000);
      tick(32'd3_110_001, 1'b1, 1'b1, 12'd4095);
      tick(32'd3_110_002, 1'b1, 1'b0, 12'd4095);
      tick(32'd3_200_000, 1'b0, 1'b1, 12'd10);
      tick(32'd4_200_000, 1'b0, 1'b1, 12'd10);
      tick(32'd4_200_001, 1'b1, 1'b0, 12'd1);
      tick(32'd4_210_001, 1'b1, 1'b0, 12'd2);
      tick(32'd5_210_001, 1'b1, 1'b0, 12'd3);
      tick(32'd5_460_001, 1'b1, 1'b0, 12'd4);
      tick(32'd5_710_001, 1'b1, 1'b0, 12'd5);
      tick(32'd5_710_002, 1'b1, 1'b0, 12'd6);
      tick(32'hFFFF_FFFF, 1'b1, 1'b0, 12'd7);
      tick(32'h000F_423F, 1'b1, 1'b0, 12'd8);

      for (int p = 1; p <= 9; p++) begin
         drain();
         count = 75;
         wide = 1'b0;
         case (p)
            1: begin
               cfg.board_is_common = 1'b0;
               cfg.max_close_tries = 4'd15;
               cfg.precharge_done_level = 12'd0;
               cfg.sense_drive_delay_us = 32'd2;
               cfg.precharge_delay_us = 32'd3;
               cfg.close_check_delay_us = 32'd4;
               cfg.open_verify_delay_us = 32'd5;
            end
            2: begin
               cfg.board_is_common = 1'b1;
               cfg.max_close_tries = 4'd1;
               cfg.precharge_done_level = 12'd4095;
               cfg.sense_drive_delay_us = 32'd0;
               cfg.precharge_delay_us = 32'd0;
               cfg.close_check_delay_us = 32'd0;
               cfg.open_verify_delay_us = 32'd0;
            end
            3: begin
               // a try limit of zero fails at the first bad check
               cfg.board_is_common = 1'b0;
               cfg.max_close_tries = 4'd0;
               cfg.precharge_done_level = ADC_BITS'($urandom_range(0, 4095));
               cfg.sense_drive_delay_us = 32'd0;
               cfg.precharge_delay_us = 32'd1;
               cfg.close_check_delay_us = 32'd0;
               cfg.open_verify_delay_us = 32'd2;
            end
            4: begin
               cfg.board_is_common = 1'b0;
               cfg.max_close_tries = 4'd3;
               cfg.precharge_done_level = 12'd2048;
               cfg.sense_drive_delay_us = '1;
               cfg.precharge_delay_us = '1;
               cfg.close_check_delay_us = '1;
               cfg.open_verify_delay_us = '1;
               count = 40;
               wide = 1'b1;
            end
            default: begin
               cfg.board_is_common = 1'($urandom_range(0, 1));
               cfg.max_close_tries = TRY_BITS'($urandom_range(0, 15));
               cfg.precharge_done_level = ADC_BITS'($urandom_range(0, 4095));
               cfg.sense_drive_delay_us = pick_delay();
               cfg.precharge_delay_us = pick_delay();
               cfg.close_check_delay_us = pick_delay();
               cfg.open_verify_delay_us = pick_delay();
            end
         endcase
         program_settings(cfg);
         if (p == 1) begin
            now_time = 32'hFFFF_FFF0;
            long_hold = 1'b1;
         end
         repeat (count) random_tick(wide);
      end
      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
